[src/spd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, codes, command/status types and the CRC16 byte update
// for the sensor packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0]  SYNC_BYTE = 8'hFA;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_TOP   = 16'h8000;

  // configuration register indexes
  localparam logic [2:0] CFG_CONFIGURED   = 3'd0;
  localparam logic [2:0] CFG_PAYLOAD_LEN  = 3'd1;
  localparam logic [2:0] CFG_CHECK_MODE   = 3'd2;
  localparam logic [2:0] CFG_LANE_MAP     = 3'd3;
  localparam logic [2:0] CFG_START_MASK   = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_FIELD     = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHECK = 2'd1;
  localparam logic [1:0] STATUS_NOT_CFG   = 2'd2;

  localparam logic MODE_XOR8  = 1'b0;
  localparam logic MODE_CRC16 = 1'b1;

  typedef struct packed {
    logic       clr_sums;     // sync seen: start a new packet
    logic       store_byte;   // payload word: store and fold into sums
    logic       set_rx_hi;    // CRC MSB word
    logic       start_drain;  // good checksum: rewind field walk
    logic       advance;      // step to the next payload byte
    logic       emit;         // load the output register
    logic [1:0] emit_status;
    logic       emit_last;
  } spd_cmd_t;

  typedef struct packed {
    logic configured;
    logic check_mode;
    logic is_sync;
    logic count_done;
    logic xor_match;
    logic crc_match;
    logic drain_last;
    logic next_start;
    logic slot_free;
  } spd_stat_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((crc & CRC_TOP) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

[src/spd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_ctrl
// Packet parse and field drain sequencer. Issues commands to the datapath
// from the accepted word and the datapath status.
// ----------------------------------------------------------------------------
module spd_ctrl
  import spd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  spd_stat_t stat_i,
  output spd_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_SYNC,
    S_PAYLOAD,
    S_CHECK,
    S_CHECK_LSB,
    S_READ,
    S_MERGE
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  always_comb begin
    in_ready_o = stat_i.slot_free &&
                 ((state_q == S_SYNC) || (state_q == S_PAYLOAD) ||
                  (state_q == S_CHECK) || (state_q == S_CHECK_LSB));
    in_fire = in_valid_i && in_ready_o;
    state_d = state_q;
    cmd_o   = '0;

    unique case (state_q)
      S_SYNC, S_PAYLOAD, S_CHECK, S_CHECK_LSB: begin
        if (in_fire && !stat_i.configured) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = STATUS_NOT_CFG;
          cmd_o.emit_last   = 1'b1;
        end else if (in_fire) begin
          unique case (state_q)
            S_SYNC: begin
              if (stat_i.is_sync) begin
                cmd_o.clr_sums = 1'b1;
                state_d        = S_PAYLOAD;
              end
            end
            S_PAYLOAD: begin
              cmd_o.store_byte = 1'b1;
              if (stat_i.count_done) begin
                state_d = S_CHECK;
              end
            end
            S_CHECK: begin
              if (stat_i.check_mode == MODE_CRC16) begin
                cmd_o.set_rx_hi = 1'b1;
                state_d         = S_CHECK_LSB;
              end else if (stat_i.xor_match) begin
                cmd_o.start_drain = 1'b1;
                state_d           = S_READ;
              end else begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STATUS_BAD_CHECK;
                cmd_o.emit_last   = 1'b1;
                state_d           = S_SYNC;
              end
            end
            default: begin
              if (stat_i.crc_match) begin
                cmd_o.start_drain = 1'b1;
                state_d           = S_READ;
              end else begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = STATUS_BAD_CHECK;
                cmd_o.emit_last   = 1'b1;
                state_d           = S_SYNC;
              end
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_MERGE;
      end
      S_MERGE: begin
        // when a result is due, hold here while the output register is still full
        if (stat_i.drain_last) begin
          if (stat_i.slot_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = STATUS_FIELD;
            cmd_o.emit_last   = 1'b1;
            state_d           = S_SYNC;
          end
        end else if (stat_i.next_start) begin
          if (stat_i.slot_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = STATUS_FIELD;
            cmd_o.advance     = 1'b1;
            state_d           = S_READ;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      default: state_d = S_SYNC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SYNC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/spd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_datapath
// Configuration registers, payload store, XOR8/CRC16 sums, field assembly
// and the output register.
// ----------------------------------------------------------------------------
module spd_datapath
  import spd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic [7:0]         data_byte_i,
  input  logic               out_ready_i,
  input  spd_cmd_t           cmd_i,
  output spd_stat_t          stat_o,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [4:0]         field_index_o,
  output logic signed [31:0] value_o,
  output logic               last_o
);

  logic              configured_q;
  logic [5:0]        payload_len_q;
  logic              check_mode_q;
  logic [63:0]       lane_map_q;
  logic [31:0]       start_mask_q;

  logic [CNT_W-1:0]  byte_count_q;
  logic [CNT_W-1:0]  byte_count_inc;
  logic [7:0]        xor_q;
  logic [15:0]       crc_q;
  logic [7:0]        rx_hi_q;
  logic [CNT_W-1:0]  eff_len;

  logic [7:0]        mem [MAX_PAYLOAD];
  logic [7:0]        rd_q;

  logic [IDX_W-1:0]  drain_idx_q;
  logic [IDX_W-1:0]  next_idx;
  logic [31:0]       acc_q;
  logic [31:0]       merged;
  logic [1:0]        lane;
  logic [4:0]        field_q;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [4:0]        field_index_q;
  logic [31:0]       value_q;
  logic              last_q;

  always_comb begin
    if (payload_len_q == 6'd0) begin
      eff_len = CNT_W'(1);
    end else if (payload_len_q > 6'(MAX_PAYLOAD)) begin
      eff_len = CNT_W'(MAX_PAYLOAD);
    end else begin
      eff_len = CNT_W'(payload_len_q);
    end
    byte_count_inc = (byte_count_q < CNT_W'(MAX_PAYLOAD)) ?
                     byte_count_q + CNT_W'(1) : byte_count_q;
    next_idx = drain_idx_q + IDX_W'(1);
    lane     = lane_map_q[{drain_idx_q, 1'b0} +: 2];
    merged   = acc_q | ({24'h000000, rd_q} << {lane, 3'b000});

    stat_o.configured = configured_q;
    stat_o.check_mode = check_mode_q;
    stat_o.is_sync    = (data_byte_i == SYNC_BYTE);
    stat_o.count_done = (byte_count_inc >= eff_len);
    stat_o.xor_match  = (xor_q == data_byte_i);
    stat_o.crc_match  = (crc_q == {rx_hi_q, data_byte_i});
    stat_o.drain_last = ({1'b0, drain_idx_q} == (eff_len - CNT_W'(1)));
    stat_o.next_start = start_mask_q[next_idx];
    stat_o.slot_free  = !out_valid_q || out_ready_i;
  end

  // configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      configured_q  <= 1'b0;
      payload_len_q <= 6'd1;
      check_mode_q  <= MODE_XOR8;
      lane_map_q    <= '0;
      start_mask_q  <= 32'h0000_0001;
      byte_count_q  <= '0;
      xor_q         <= '0;
      crc_q         <= '0;
      rx_hi_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_CONFIGURED:  configured_q  <= cfg_data_i[0];
          CFG_PAYLOAD_LEN: payload_len_q <= cfg_data_i[5:0];
          CFG_CHECK_MODE:  check_mode_q  <= cfg_data_i[0];
          CFG_LANE_MAP:    lane_map_q    <= cfg_data_i;
          CFG_START_MASK:  start_mask_q  <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_sums) begin
        byte_count_q <= '0;
        xor_q        <= '0;
        crc_q        <= '0;
        rx_hi_q      <= '0;
      end
      if (cmd_i.store_byte) begin
        byte_count_q <= byte_count_inc;
        xor_q        <= xor_q ^ data_byte_i;
        crc_q        <= crc16_update(crc_q, data_byte_i);
      end
      if (cmd_i.set_rx_hi) begin
        rx_hi_q <= data_byte_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload store, read at the drain index every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte && (byte_count_q < CNT_W'(MAX_PAYLOAD))) begin
      mem[byte_count_q[IDX_W-1:0]] <= data_byte_i;
    end
    rd_q <= mem[drain_idx_q];
  end

  // field walk and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_drain) begin
      drain_idx_q <= '0;
      acc_q       <= '0;
      field_q     <= '0;
    end else begin
      if (cmd_i.advance) begin
        drain_idx_q <= next_idx;
        acc_q       <= cmd_i.emit ? 32'h0000_0000 : merged;
      end
      if (cmd_i.emit && (cmd_i.emit_status == STATUS_FIELD)) begin
        field_q <= field_q + 5'd1;
      end
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      last_q   <= cmd_i.emit_last;
      if (cmd_i.emit_status == STATUS_FIELD) begin
        field_index_q <= field_q;
        value_q       <= merged;
      end else begin
        field_index_q <= '0;
        value_q       <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign field_index_o = field_index_q;
  assign value_o       = signed'(value_q);
  assign last_o        = last_q;

endmodule

[src/sensor_packet_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_packet_deframer
// Sync-byte framed packet deframer with XOR8 or CRC16 check, field output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, data_byte_i) takes one received word
//   per handshake. Outside a packet words are dropped until the sync byte 0xFA.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is always
//   ready; write it only while the block is idle.
//   Output channel (out_valid_o/out_ready_i) carries status, field_index, value
//   and last. A bad checksum gives one error result; a good one gives one
//   result per field, the final one with last set.
//   Sequence: sync, payload and checksum words are accepted while the output
//   register has room. After a good checksum the field walk reads each payload
//   byte from the store and then merges it (store read, then merge); a merge
//   that owes a result waits for room, and input is held off during the walk.
//   An unconfigured block answers each word with a result the next cycle.
//   Reset returns the parser to sync search and restores the register defaults;
//   the payload store is not cleared. When the receiver stalls, the result is
//   held in the output register; input and the next field result wait for it.
// ----------------------------------------------------------------------------
module sensor_packet_deframer
  import spd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [4:0]         field_index_o,
  output logic signed [31:0] value_o,
  output logic               last_o
);

  spd_cmd_t  cmd;
  spd_stat_t stat;

  assign cfg_ready_o = 1'b1;

  spd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .data_byte_i   (data_byte_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .field_index_o (field_index_o),
    .value_o       (value_o),
    .last_o        (last_o)
  );

endmodule

[src/spd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks for the sensor packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module spd_checker
  import spd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         status_o,
  input logic [4:0]         field_index_o,
  input logic signed [31:0] value_o,
  input logic               last_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) &&
      $stable(status_o) && $stable(field_index_o) && $stable(last_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_FIELD) |->
      last_o && (field_index_o == 5'd0) && (value_o == 32'sd0))
    else $error("error result not a closing zero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_FIELD) || (status_o == STATUS_BAD_CHECK) ||
      (status_o == STATUS_NOT_CFG))
    else $error("undefined status code");

  // no word taken while a result is stuck in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted with output register full");

endmodule

bind sensor_packet_deframer spd_checker u_spd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .field_index_o (field_index_o),
  .value_o       (value_o),
  .last_o        (last_o)
);

[tb/tb_sensor_packet_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_packet_deframer
// Drives framed byte streams into the deframer and checks every field and
// error result against a cycle-free predictor of the parser. Directed tests
// cover the corner cases first; then random packets run across changing
// register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_sensor_packet_deframer;
  import spd_pkg::*;

  localparam int          CLK_PERIOD    = 8;
  localparam int          RESET_CYCLES  = 7;
  localparam int          SETTLE_CYCLES = 2 * MAX_PAYLOAD + 8;
  localparam int          RANDOM_ITEMS  = 450;
  localparam int          MAX_REPORTS   = 40;
  localparam longint      TIMEOUT_NS    = 2_000_000;
  // no register lives at this index
  localparam logic [2:0]  CFG_UNMAPPED  = 3'd7;

  typedef enum logic [1:0] {
    PS_HUNT,
    PS_BODY,
    PS_CHECK_HI,
    PS_CHECK_LO
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  field_index;
    logic [31:0] value;
    logic        last;
  } field_word_t;

  typedef logic [7:0] byte_q_t [$];

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = CFG_CONFIGURED;
  logic [63:0]        cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic [4:0]         field_index_o;
  logic signed [31:0] value_o;
  logic               last_o;

  // register shadow
  logic        cfg_on     = 1'b0;
  logic [5:0]  cfg_len    = 6'd1;
  logic        cfg_mode   = MODE_XOR8;
  logic [63:0] cfg_lanes  = '0;
  logic [31:0] cfg_starts = 32'd1;

  // parser shadow
  parse_phase_e pkt_state = PS_HUNT;
  logic [5:0]   pkt_count = '0;
  logic [7:0]   pkt_bytes [MAX_PAYLOAD];
  logic [7:0]   run_xor   = '0;
  logic [15:0]  run_crc   = '0;
  logic [15:0]  got_check = '0;

  field_word_t awaited_fields [$];
  field_word_t head_word;
  int          mismatch_count = 0;
  int          useful_items   = 0;
  bit          in_calm        = 1'b0;
  bit          out_calm       = 1'b0;

  sensor_packet_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .field_index_o (field_index_o),
    .value_o       (value_o),
    .last_o        (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic int eff_len();
    if (cfg_len == 6'd0) return 1;
    if (cfg_len > MAX_PAYLOAD) return MAX_PAYLOAD;
    return int'(cfg_len);
  endfunction

  function automatic void expect_word(input logic [1:0] status, input logic [4:0] idx,
                                      input logic [31:0] value, input logic last);
    field_word_t w;
    w.status      = status;
    w.field_index = idx;
    w.value       = value;
    w.last        = last;
    awaited_fields = {awaited_fields, w};
  endfunction

  function automatic void close_packet(input bit good);
    logic [31:0] acc;
    logic [4:0]  fidx;
    int          n;
    pkt_state = PS_HUNT;
    if (!good) begin
      expect_word(STATUS_BAD_CHECK, 5'd0, 32'd0, 1'b1);
      return;
    end
    n    = eff_len();
    acc  = '0;
    fidx = '0;
    for (int i = 0; i < n; i++) begin
      // byte 0 always opens the first field
      if (i != 0 && cfg_starts[5'(i)]) begin
        expect_word(STATUS_FIELD, fidx, acc, 1'b0);
        fidx++;
        acc = '0;
      end
      acc = acc | (32'(pkt_bytes[5'(i)]) << (8 * cfg_lanes[6'(2 * i) +: 2]));
    end
    expect_word(STATUS_FIELD, fidx, acc, 1'b1);
  endfunction

  // Returns 0 only for a word that is dropped while hunting for sync.
  function automatic bit deframe_byte(input logic [7:0] b);
    if (!cfg_on) begin
      expect_word(STATUS_NOT_CFG, 5'd0, 32'd0, 1'b1);
      return 1'b1;
    end
    case (pkt_state)
      PS_HUNT: begin
        if (b != SYNC_BYTE) return 1'b0;
        pkt_count = '0;
        run_xor   = '0;
        run_crc   = '0;
        got_check = '0;
        pkt_state = PS_BODY;
      end
      PS_BODY: begin
        if (pkt_count < MAX_PAYLOAD) begin
          pkt_bytes[pkt_count[4:0]] = b;
          pkt_count++;
        end
        run_xor = run_xor ^ b;
        run_crc = crc16_step(run_crc, b);
        if (pkt_count >= eff_len()) pkt_state = PS_CHECK_HI;
      end
      PS_CHECK_HI: begin
        if (cfg_mode == MODE_XOR8) begin
          got_check = {8'h00, b};
          close_packet(run_xor == b);
        end else begin
          got_check = {b, 8'h00};
          pkt_state = PS_CHECK_LO;
        end
      end
      default: begin
        // low CRC byte is a CRC compare whatever the mode is now
        got_check = got_check | {8'h00, b};
        close_packet(run_crc == got_check);
      end
    endcase
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s expected %h, got %h", name, want, got));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_fields.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d index=%0d value=%h last=%0b",
                                  status_o, field_index_o, value_o, last_o));
      end else begin
        head_word = awaited_fields.pop_front();
        check_field("status", 32'(status_o), 32'(head_word.status));
        check_field("field_index", 32'(field_index_o), 32'(head_word.field_index));
        check_field("value", value_o, head_word.value);
        check_field("last", 32'(last_o), 32'(head_word.last));
      end
    end
  end

  // -------------------------------------------------------------- channel I/O

  function automatic int unsigned draw_gap(input bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 17);
    return $urandom_range(0, 3);
  endfunction

  // receiver: one stall draw per result word
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = draw_gap(out_calm);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (deframe_byte(b)) useful_items++;
  endtask

  task automatic drain_results();
    if (awaited_fields.size() != 0) begin
      in_valid_i <= 1'b0;
      while (awaited_fields.size() != 0) @(posedge clk_i);
    end
  endtask

  // drain, then let a field walk that produces no word run out
  task automatic wait_idle();
    drain_results();
    in_valid_i <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CONFIGURED:  cfg_on     = data[0];
      CFG_PAYLOAD_LEN: cfg_len    = data[5:0];
      CFG_CHECK_MODE:  cfg_mode   = data[0];
      CFG_LANE_MAP:    cfg_lanes  = data;
      CFG_START_MASK:  cfg_starts = data[31:0];
      default: ;
    endcase
  endtask

  task automatic close_cfg();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_packet(input byte_q_t body, input bit corrupt);
    logic [7:0]  sum8;
    logic [15:0] sum16;
    sum8  = '0;
    sum16 = '0;
    send_byte(SYNC_BYTE);
    foreach (body[i]) begin
      send_byte(body[i]);
      sum8  = sum8 ^ body[i];
      sum16 = crc16_step(sum16, body[i]);
    end
    if (cfg_mode == MODE_XOR8) begin
      if (corrupt) sum8 = sum8 ^ 8'($urandom_range(1, 255));
      send_byte(sum8);
    end else begin
      if (corrupt) sum16 = sum16 ^ 16'($urandom_range(1, 65535));
      send_byte(sum16[15:8]);
      send_byte(sum16[7:0]);
    end
  endtask

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) begin
      q = {q, (($urandom_range(0, 15) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255)))};
    end
    return q;
  endfunction

  // ------------------------------------------------------------------- tests

  task automatic test_unconfigured_words();
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(8'hFF);
  endtask

  task automatic test_xor_min_length();
    wait_idle();
    write_reg(CFG_CONFIGURED, 64'd1);
    write_reg(CFG_PAYLOAD_LEN, 64'd0);
    write_reg(CFG_CHECK_MODE, 64'(MODE_XOR8));
    write_reg(CFG_LANE_MAP, 64'd0);
    write_reg(CFG_START_MASK, 64'd0);
    write_reg(CFG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    close_cfg();
    send_packet('{8'h80}, 1'b0);
  endtask

  task automatic test_crc_byte_lanes();
    wait_idle();
    write_reg(CFG_PAYLOAD_LEN, 64'd4);
    write_reg(CFG_CHECK_MODE, 64'(MODE_CRC16));
    // bytes 0..3 into lanes 3..0, big-endian word
    write_reg(CFG_LANE_MAP, 64'h1B);
    close_cfg();
    send_packet('{8'hFF, SYNC_BYTE, 8'h00, 8'h7F}, 1'b0);
  endtask

  task automatic test_bad_checksum();
    wait_idle();
    write_reg(CFG_PAYLOAD_LEN, 64'd1);
    write_reg(CFG_CHECK_MODE, 64'(MODE_XOR8));
    close_cfg();
    send_packet('{8'h01}, 1'b1);
  endtask

  task automatic test_mode_switch_between_crc();
    logic [15:0] crc;
    crc = crc16_step(16'h0000, 8'h5A);
    wait_idle();
    write_reg(CFG_CHECK_MODE, 64'(MODE_CRC16));
    close_cfg();
    send_byte(SYNC_BYTE);
    send_byte(8'h5A);
    send_byte(crc[15:8]);
    wait_idle();
    write_reg(CFG_CHECK_MODE, 64'(MODE_XOR8));
    close_cfg();
    send_byte(crc[7:0]);
  endtask

  task automatic test_length_cut_mid_packet();
    wait_idle();
    write_reg(CFG_PAYLOAD_LEN, 64'd32);
    write_reg(CFG_LANE_MAP, 64'h4);
    write_reg(CFG_START_MASK, 64'h2);
    close_cfg();
    send_byte(SYNC_BYTE);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    // disabled parser answers but keeps the packet where it was
    wait_idle();
    write_reg(CFG_CONFIGURED, 64'd0);
    close_cfg();
    send_byte(8'h55);
    wait_idle();
    write_reg(CFG_CONFIGURED, 64'd1);
    write_reg(CFG_PAYLOAD_LEN, 64'd2);
    close_cfg();
    send_byte(8'h44);
    send_byte(8'h11 ^ 8'h22 ^ 8'h33 ^ 8'h44);
  endtask

  task automatic configure_phase(input int phase);
    logic [5:0]  len;
    logic        mode;
    logic [63:0] lanes;
    logic [31:0] starts;
    logic        on;
    int          pick;
    wait_idle();
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    // finish any open packet before the length may grow
    if (!cfg_on || pkt_state != PS_HUNT) begin
      if (!cfg_on) begin
        write_reg(CFG_CONFIGURED, 64'd1);
        close_cfg();
      end
      while (pkt_state != PS_HUNT) send_byte(8'($urandom_range(0, 255)));
      wait_idle();
    end
    on = 1'b1;
    case (phase)
      0: begin
        len = 6'd63; mode = MODE_CRC16; lanes = '1; starts = '1;
      end
      1: begin
        len = 6'd0; mode = MODE_XOR8; lanes = '0; starts = '0;
      end
      2: begin
        len = 6'd32; mode = MODE_XOR8; lanes = {$urandom, $urandom}; starts = '0;
      end
      default: begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          len = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
        end else if (pick <= 6) begin
          len = 6'($urandom_range(1, 8));
        end else begin
          len = 6'($urandom_range(9, 32));
        end
        mode  = 1'($urandom_range(0, 1));
        lanes = {$urandom, $urandom};
        pick  = $urandom_range(0, 3);
        if (pick == 0) begin
          starts = $urandom & $urandom & $urandom;
        end else if (pick == 1) begin
          starts = '1;
        end else begin
          starts = $urandom;
        end
        on = ($urandom_range(0, 5) != 0);
      end
    endcase
    write_reg(CFG_PAYLOAD_LEN, 64'(len));
    write_reg(CFG_CHECK_MODE, 64'(mode));
    write_reg(CFG_LANE_MAP, lanes);
    write_reg(CFG_START_MASK, 64'(starts));
    write_reg(CFG_CONFIGURED, 64'(on));
    close_cfg();
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          noise;
    logic [7:0]  junk;
    phase        = 0;
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      configure_phase(phase);
      phase++;
      if (!cfg_on) begin
        repeat ($urandom_range(2, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(2, 6)) begin
          if (useful_items >= RANDOM_ITEMS) break;
          if ($urandom_range(0, 2) == 0) begin
            noise = $urandom_range(1, 4);
            repeat (noise) begin
              // skip the sync value so the packet below starts cleanly
              junk = 8'($urandom_range(0, 254));
              if (junk >= SYNC_BYTE) junk++;
              send_byte(junk);
            end
          end
          send_packet(random_body(eff_len()), $urandom_range(0, 6) == 0);
          if ($urandom_range(0, 7) == 0) drain_results();
        end
      end
    end
  endtask

  // -------------------------------------------------------------------- main

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_unconfigured_words();
    test_xor_min_length();
    test_crc_byte_lanes();
    test_bad_checksum();
    test_mode_switch_between_crc();
    test_length_cut_mid_packet();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("** sensor_packet_deframer: PASSED **");
    end else begin
      $display("** sensor_packet_deframer: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d words outstanding", awaited_fields.size());
    $display("** sensor_packet_deframer: FAILED **");
    $finish;
  end

endmodule
